FILE: src/rpc_pkg.sv
package rpc_pkg;

    // default store depth
    localparam int MaxElements = 1024;

    // result count width and saturation point
    localparam int             CountW   = 19;
    localparam logic [18:0]    CountMax = 19'h7FFFF;

    // controller states
    typedef enum logic [3:0] {
        S_LOAD,
        S_CHK,
        S_CNT_RD,
        S_CNT_EV,
        S_MRG_RD,
        S_MRG_EV,
        S_CPY_RD,
        S_CPY_WR,
        S_NEXT,
        S_OUT
    } t_state;

    // controller to datapath commands
    typedef struct packed {
        logic load;      // store incoming word
        logic init_sort; // width = 1, lo = 0
        logic init_run;  // set up bounds of one merge
        logic cnt_r;     // advance right pointer of count sweep
        logic cnt_i;     // close one left element, accumulate
        logic mrg_sel;   // read ports follow merge pointers
        logic mrg;       // emit one merged word into scratch
        logic cpy_init;  // k = lo
        logic cpy_step;  // scratch word back to store
        logic next;      // step to next run or next width
        logic clear;     // result taken, start over
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic run_go;    // lo + width < n
        logic adv;       // right pointer in run, left > twice right
        logic i_last;    // left pointer at last element of run
        logic k_last;    // output pointer at last element
    } t_stat;

endpackage

FILE: src/rpc_ram.sv
module rpc_ram #(
    parameter int W = 32,
    parameter int D = 1024
) (
    input  logic                 i_clk,
    input  logic                 i_wr_en,
    input  logic [$clog2(D)-1:0] i_wr_addr,
    input  logic [W-1:0]         i_wr_data,
    input  logic [$clog2(D)-1:0] i_rd_addr_a,
    input  logic [$clog2(D)-1:0] i_rd_addr_b,
    output logic [W-1:0]         o_rd_data_a,
    output logic [W-1:0]         o_rd_data_b
);

    logic [W-1:0] mem [D];

    // one write, two registered reads
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data_a <= mem[i_rd_addr_a];
        o_rd_data_b <= mem[i_rd_addr_b];
    end

endmodule

FILE: src/rpc_ctrl.sv
module rpc_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic           i_is_last,
    input  rpc_pkg::t_stat i_stat,
    output rpc_pkg::t_cmd  o_cmd,
    output logic           o_busy,
    output logic           o_done
);

    rpc_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rpc_pkg::S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            rpc_pkg::S_LOAD: begin
                if (i_start && i_is_last) n_state = rpc_pkg::S_CHK;
            end
            rpc_pkg::S_CHK: begin
                n_state = i_stat.run_go ? rpc_pkg::S_CNT_RD : rpc_pkg::S_OUT;
            end
            rpc_pkg::S_CNT_RD: n_state = rpc_pkg::S_CNT_EV;
            rpc_pkg::S_CNT_EV: begin
                if (i_stat.adv)         n_state = rpc_pkg::S_CNT_RD;
                else if (i_stat.i_last) n_state = rpc_pkg::S_MRG_RD;
                else                    n_state = rpc_pkg::S_CNT_RD;
            end
            rpc_pkg::S_MRG_RD: n_state = rpc_pkg::S_MRG_EV;
            rpc_pkg::S_MRG_EV: begin
                n_state = i_stat.k_last ? rpc_pkg::S_CPY_RD : rpc_pkg::S_MRG_RD;
            end
            rpc_pkg::S_CPY_RD: n_state = rpc_pkg::S_CPY_WR;
            rpc_pkg::S_CPY_WR: begin
                n_state = i_stat.k_last ? rpc_pkg::S_NEXT : rpc_pkg::S_CPY_RD;
            end
            rpc_pkg::S_NEXT:   n_state = rpc_pkg::S_CHK;
            rpc_pkg::S_OUT:    n_state = rpc_pkg::S_LOAD;
            default:           n_state = rpc_pkg::S_LOAD;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd  = '0;
        o_busy = 1'b1;
        o_done = 1'b0;
        case (r_state)
            rpc_pkg::S_LOAD: begin
                o_busy         = 1'b0;
                o_cmd.load     = i_start;
                o_cmd.init_sort = i_start && i_is_last;
            end
            rpc_pkg::S_CHK:    o_cmd.init_run = i_stat.run_go;
            rpc_pkg::S_CNT_RD: ;
            rpc_pkg::S_CNT_EV: begin
                o_cmd.cnt_r = i_stat.adv;
                o_cmd.cnt_i = !i_stat.adv;
            end
            rpc_pkg::S_MRG_RD: o_cmd.mrg_sel = 1'b1;
            rpc_pkg::S_MRG_EV: begin
                o_cmd.mrg      = 1'b1;
                o_cmd.cpy_init = i_stat.k_last;
            end
            rpc_pkg::S_CPY_RD: ;
            rpc_pkg::S_CPY_WR: o_cmd.cpy_step = 1'b1;
            rpc_pkg::S_NEXT:   o_cmd.next = 1'b1;
            rpc_pkg::S_OUT: begin
                o_done      = 1'b1;
                o_cmd.clear = 1'b1;
            end
            default: ;
        endcase
    end

endmodule

FILE: src/rpc_dp.sv
module rpc_dp #(
    parameter int MAX_ELEMENTS = rpc_pkg::MaxElements
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  rpc_pkg::t_cmd               i_cmd,
    input  logic [31:0]                 i_sample_value,
    output rpc_pkg::t_stat              o_stat,
    output logic [rpc_pkg::CountW-1:0]  o_pair_count,
    output logic                        o_length_overflow
);

    localparam int AW = $clog2(MAX_ELEMENTS);
    localparam int CW = $clog2(MAX_ELEMENTS + 1);
    localparam int XW = CW + 2;

    logic [CW-1:0] r_n;
    logic          r_ovf;
    logic [rpc_pkg::CountW-1:0] r_acc;
    logic [CW:0]   r_w;
    logic [CW-1:0] r_lo, r_mid, r_hi, r_i, r_r, r_a, r_b, r_k;

    logic [31:0]   q_a, q_b, q_s;
    logic          st_we, sc_we;
    logic [AW-1:0] st_waddr, rd_a, rd_b;
    logic [31:0]   st_wdata, sc_wdata;
    logic          take_a, room;
    logic signed [33:0] cmp_l, cmp_r;
    logic [rpc_pkg::CountW:0] acc_sum;
    logic [XW-1:0] lo_w, lo_2w, nxt_lo;

    // element store and merge scratch
    rpc_ram #(.W(32), .D(MAX_ELEMENTS)) u_store (
        .i_clk       (i_clk),
        .i_wr_en     (st_we),
        .i_wr_addr   (st_waddr),
        .i_wr_data   (st_wdata),
        .i_rd_addr_a (rd_a),
        .i_rd_addr_b (rd_b),
        .o_rd_data_a (q_a),
        .o_rd_data_b (q_b)
    );

    rpc_ram #(.W(32), .D(MAX_ELEMENTS)) u_scratch (
        .i_clk       (i_clk),
        .i_wr_en     (sc_we),
        .i_wr_addr   (r_k[AW-1:0]),
        .i_wr_data   (sc_wdata),
        .i_rd_addr_a (r_k[AW-1:0]),
        .i_rd_addr_b (r_k[AW-1:0]),
        .o_rd_data_a (q_s),
        .o_rd_data_b ()
    );

    // port addresses and write muxing
    always_comb begin
        room     = r_n < CW'(MAX_ELEMENTS);
        rd_a     = i_cmd.mrg_sel ? r_a[AW-1:0] : r_i[AW-1:0];
        rd_b     = i_cmd.mrg_sel ? r_b[AW-1:0] : r_r[AW-1:0];
        st_we    = (i_cmd.load && room) || i_cmd.cpy_step;
        st_waddr = i_cmd.cpy_step ? r_k[AW-1:0] : r_n[AW-1:0];
        st_wdata = i_cmd.cpy_step ? q_s : i_sample_value;
        take_a   = (r_a < r_mid) && ((r_b >= r_hi) || ($signed(q_a) < $signed(q_b)));
        sc_we    = i_cmd.mrg;
        sc_wdata = take_a ? q_a : q_b;
    end

    // 34-bit compare, doubling cannot overflow
    always_comb begin
        cmp_l = {{2{q_a[31]}}, q_a};
        cmp_r = {q_b[31], q_b, 1'b0};
    end

    // run bounds arithmetic
    always_comb begin
        lo_w   = XW'(r_lo) + XW'(r_w);
        lo_2w  = lo_w + XW'(r_w);
        nxt_lo = lo_2w + XW'(r_w);
    end

    always_comb begin
        acc_sum = {1'b0, r_acc} + (rpc_pkg::CountW + 1)'(r_r - r_mid);
    end

    // status to controller
    always_comb begin
        o_stat.run_go = lo_w < XW'(r_n);
        o_stat.adv    = (r_r < r_hi) && (cmp_l > cmp_r);
        o_stat.i_last = (XW'(r_i) + XW'(1)) == XW'(r_mid);
        o_stat.k_last = (XW'(r_k) + XW'(1)) == XW'(r_hi);
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n   <= '0;
            r_ovf <= 1'b0;
            r_acc <= '0;
        end else if (i_cmd.clear) begin
            r_n   <= '0;
            r_ovf <= 1'b0;
            r_acc <= '0;
        end else begin
            if (i_cmd.load) begin
                if (room) r_n   <= r_n + CW'(1);
                else      r_ovf <= 1'b1;
            end
            if (i_cmd.cnt_i) begin
                r_acc <= (acc_sum > {1'b0, rpc_pkg::CountMax}) ?
                         rpc_pkg::CountMax : acc_sum[rpc_pkg::CountW-1:0];
            end
        end
    end

    // sort pointers
    always_ff @(posedge i_clk) begin
        if (i_cmd.init_sort) begin
            r_w  <= (CW + 1)'(1);
            r_lo <= '0;
        end
        if (i_cmd.next) begin
            if (nxt_lo < XW'(r_n)) begin
                r_lo <= lo_2w[CW-1:0];
            end else begin
                r_lo <= '0;
                r_w  <= {r_w[CW-1:0], 1'b0};
            end
        end
        if (i_cmd.init_run) begin
            r_mid <= lo_w[CW-1:0];
            r_hi  <= (lo_2w < XW'(r_n)) ? lo_2w[CW-1:0] : r_n;
            r_i   <= r_lo;
            r_a   <= r_lo;
            r_k   <= r_lo;
            r_r   <= lo_w[CW-1:0];
            r_b   <= lo_w[CW-1:0];
        end
        if (i_cmd.cnt_r) r_r <= r_r + CW'(1);
        if (i_cmd.cnt_i) r_i <= r_i + CW'(1);
        if (i_cmd.mrg) begin
            if (take_a) r_a <= r_a + CW'(1);
            else        r_b <= r_b + CW'(1);
        end
        // output pointer: rewinds for the copy after the last merged word
        if (i_cmd.cpy_init) begin
            r_k <= r_lo;
        end else if (i_cmd.mrg || i_cmd.cpy_step) begin
            r_k <= r_k + CW'(1);
        end
    end

    assign o_pair_count      = r_acc;
    assign o_length_overflow = r_ovf;

endmodule

FILE: src/reverse_pair_counter_unit.sv
// Channel   Handshake                     Ports
// input     start & !busy accepts a word  i_sample_value, i_is_last
// result    o_done, one cycle, no stall   o_pair_count, o_length_overflow
//
// A word without the last flag is stored, and the block stays ready.
// The last word starts a bottom-up merge sort over the stored n words:
// each pass over width counts pairs for every merge (two-read store
// port, registered), merges each run pair into scratch word by word
// and copies each merged word back, then the result is presented.
// busy stays high from the last word until the result cycle has ended.
// Reset is synchronous, active low; the stores themselves are not cleared.
module reverse_pair_counter_unit #(
    parameter int MAX_ELEMENTS = rpc_pkg::MaxElements
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    input  logic [31:0]                i_sample_value,
    input  logic                       i_is_last,
    output logic                       busy,
    output logic                       o_done,
    output logic [rpc_pkg::CountW-1:0] o_pair_count,
    output logic                       o_length_overflow
);

    rpc_pkg::t_cmd  cmd;
    rpc_pkg::t_stat stat;

    rpc_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_is_last (i_is_last),
        .i_stat    (stat),
        .o_cmd     (cmd),
        .o_busy    (busy),
        .o_done    (o_done)
    );

    rpc_dp #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .i_sample_value    (i_sample_value),
        .o_stat            (stat),
        .o_pair_count      (o_pair_count),
        .o_length_overflow (o_length_overflow)
    );

endmodule

FILE: src/rpc_checker.sv
module rpc_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic i_is_last,
    input logic busy,
    input logic o_done
);

    // result strobe lasts a single cycle
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("result strobe held");

    // no result while words are accepted
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> busy) else $error("result while idle");

    // a plain word leaves the block ready
    a_plain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && !i_is_last) |=> !busy) else $error("busy after plain word");

    // the last word starts the sort
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_is_last) |=> busy) else $error("last word ignored");

    // reset leaves the block ready and quiet
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> (!busy && !o_done)) else $error("not idle after reset");

endmodule

bind reverse_pair_counter_unit rpc_checker u_rpc_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .start     (start),
    .i_is_last (i_is_last),
    .busy      (busy),
    .o_done    (o_done)
);
